### sv/asfe_pkg.sv
// asfe_pkg: shared widths, character codes and the queue entry type
// for the slider frame encoder; no dependencies
package asfe_pkg;

  localparam int TGT_W     = 8;
  localparam int VAL_W     = 32;
  localparam int LIMIT_W   = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam int MAX_FRAME   = 15;
  localparam int MAX_DIGITS  = 12;
  localparam int DIG_BITS    = MAX_DIGITS * 4;
  localparam int DIG_PTR_W   = 4;
  localparam int LEN_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NULL   = 8'h00;
  localparam logic [7:0] TGT_R     = 8'h52;
  localparam logic [7:0] TGT_P     = 8'h50;
  localparam logic [7:0] TGT_N     = 8'h4E;

  typedef struct packed {
    logic                 err;
    logic                 neg;
    logic [TGT_W-1:0]     target;
    logic [DIG_PTR_W-1:0] nint;
    logic [DIG_BITS-1:0]  digits;
  } asfe_entry_t;

endpackage

### sv/asfe_if.sv
// asfe_if: valid/ready channel interfaces for input, result and config beats
// depends on asfe_pkg
interface asfe_in_if import asfe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TGT_W-1:0]        target_code;
  logic signed [VAL_W-1:0] value_fixed;
  modport source (output valid, target_code, value_fixed, input ready);
  modport sink (input valid, target_code, value_fixed, output ready);
endinterface

interface asfe_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       frame_error;
  modport source (output valid, frame_byte, last_byte, frame_error, input ready);
  modport sink (input valid, frame_byte, last_byte, frame_error, output ready);
endinterface

interface asfe_cfg_if import asfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] frame_limit;
  modport source (output valid, frame_limit, input ready);
  modport sink (input valid, frame_limit, output ready);
endinterface

### sv/ascii_slider_frame_encoder_unit.sv
// ascii_slider_frame_encoder_unit: top level, frame_limit register and the
// front / queue / back chain; depends on asfe_pkg, asfe_if and submodules
// the front holds one further input beat in its buffer while it converts
// the previous one, so input and conversion overlap
// reset: synchronous active-low, clears all control state, frame_limit to 32
module ascii_slider_frame_encoder_unit import asfe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  asfe_in_if.sink    in_if,
  asfe_out_if.source out_if,
  asfe_cfg_if.sink   cfg_if
);

  logic [LIMIT_W-1:0] limit_r;
  logic               push_valid;
  logic               push_ready;
  asfe_entry_t        push_entry;
  logic               q_valid;
  logic               q_pop;
  asfe_entry_t        q_entry;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      limit_r <= cfg_if.frame_limit;
    end
  end

  asfe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .frame_limit (limit_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  asfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (q_valid),
    .rd_ready (q_pop),
    .rd_entry (q_entry)
  );

  asfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_entry (q_entry),
    .out_if  (out_if)
  );

endmodule

### sv/asfe_front.sv
// asfe_front: input buffer, target check, rounding to hundredths and
// two-bit-per-cycle binary to bcd conversion; depends on asfe_pkg, asfe_if
module asfe_front import asfe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  asfe_in_if.sink            in_if,
  input  logic [LIMIT_W-1:0] frame_limit,
  output logic               push_valid,
  input  logic               push_ready,
  output asfe_entry_t        push_entry
);

  localparam int PROD_W = 38;
  localparam int SW     = PROD_W - FRAC_BITS;
  localparam int SWE    = ((SW + 1) / 2) * 2;
  localparam int ND     = (SW * 30103) / 100000 + 1;
  localparam int STEPS  = SWE / 2;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam logic [PROD_W-1:0] HALF =
    (FRAC_BITS > 0) ? (PROD_W'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_CONV, F_FIN} fstate_t;

  fstate_t            state_r;
  logic               hold_vld_r;
  logic [TGT_W-1:0]   hold_tgt_r;
  logic [VAL_W-1:0]   hold_val_r;
  logic [TGT_W-1:0]   tgt_r;
  logic               neg_r;
  logic               err_r;
  logic [VAL_W-1:0]   mag_r;
  logic [SWE-1:0]     scaled_r;
  logic [ND*4-1:0]    bcd_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               take;
  logic               tgt_ok;
  logic [PROD_W-1:0]  prod;
  logic [ND*4-1:0]    bcd_nxt;
  logic [DIG_PTR_W-1:0] nint_w;
  logic [LEN_W-1:0]   len_w;

  assign take        = (state_r == F_IDLE) && hold_vld_r;
  assign in_if.ready = !hold_vld_r || take;
  assign tgt_ok      = (hold_tgt_r == TGT_R) || (hold_tgt_r == TGT_P) || (hold_tgt_r == TGT_N);
  assign prod        = (PROD_W'(mag_r) << 6) + (PROD_W'(mag_r) << 5)
                     + (PROD_W'(mag_r) << 2) + HALF;

  // double dabble, two bits per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    for (int s = 0; s < 2; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_nxt[d*4 +: 4] >= 4'd5) bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
      end
      bcd_nxt = {bcd_nxt[ND*4-2:0], scaled_r[SWE-1-s]};
    end
  end

  // integer digit count, at least one
  always_comb begin
    nint_w = DIG_PTR_W'(1);
    for (int i = 2; i < ND; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) nint_w = DIG_PTR_W'(i - 1);
    end
  end

  assign len_w = LEN_W'(9) + LEN_W'(neg_r) + LEN_W'(nint_w);

  assign push_valid        = (state_r == F_FIN);
  assign push_entry.err    = err_r || ((LIMIT_W + 1)'(len_w) > (LIMIT_W + 1)'(frame_limit))
                           || (len_w > LEN_W'(MAX_FRAME));
  assign push_entry.neg    = neg_r;
  assign push_entry.target = tgt_r;
  assign push_entry.nint   = nint_w;
  assign push_entry.digits = DIG_BITS'(bcd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      hold_vld_r <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        hold_vld_r <= 1'b1;
        hold_tgt_r <= in_if.target_code;
        hold_val_r <= in_if.value_fixed;
      end else if (take) begin
        hold_vld_r <= 1'b0;
      end
      case (state_r)
        F_IDLE: begin
          if (take) begin
            tgt_r   <= hold_tgt_r;
            neg_r   <= hold_val_r[VAL_W-1];
            mag_r   <= hold_val_r[VAL_W-1] ? (~hold_val_r + VAL_W'(1)) : hold_val_r;
            err_r   <= !tgt_ok;
            state_r <= tgt_ok ? F_MUL : F_FIN;
          end
        end
        F_MUL: begin
          scaled_r <= SWE'(prod >> FRAC_BITS);
          bcd_r    <= '0;
          cnt_r    <= '0;
          state_r  <= F_CONV;
        end
        F_CONV: begin
          bcd_r    <= bcd_nxt;
          scaled_r <= scaled_r << 2;
          cnt_r    <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(STEPS - 1)) state_r <= F_FIN;
        end
        F_FIN: begin
          if (push_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/asfe_queue.sv
// asfe_queue: short register queue of frame entries between front and back
// depends on asfe_pkg
module asfe_queue import asfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  asfe_entry_t wr_entry,
  output logic        rd_valid,
  input  logic        rd_ready,
  output asfe_entry_t rd_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  asfe_entry_t      mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = mem[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) count_r <= count_r + CNT_W'(1);
      else if (do_rd && !do_wr) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

### sv/asfe_back.sv
// asfe_back: byte sequencer that turns a queued entry into frame beats
// behind an output register; depends on asfe_pkg, asfe_if
module asfe_back import asfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  asfe_entry_t q_entry,
  asfe_out_if.source  out_if
);

  typedef enum logic [3:0] {
    B_IDLE, B_HDR, B_SIGN, B_INT, B_DOT, B_F1, B_F0, B_END, B_ERR
  } bstate_t;

  bstate_t              state_r;
  asfe_entry_t          cur_r;
  logic [2:0]           hdr_cnt_r;
  logic [DIG_PTR_W-1:0] dig_ptr_r;
  logic                 out_vld_r;
  logic [7:0]           byte_r;
  logic                 last_r;
  logic                 err_r;

  logic                 slot_free;
  logic                 emit;
  logic [7:0]           hdr_byte;
  logic [7:0]           int_byte;
  logic [7:0]           f1_byte;
  logic [7:0]           f0_byte;

  assign slot_free = !out_vld_r || out_if.ready;
  assign emit      = slot_free && (state_r inside {[B_HDR:B_ERR]});
  assign q_pop     = (state_r == B_IDLE) && q_valid;

  assign int_byte = CH_ZERO + {4'd0, cur_r.digits[dig_ptr_r*4 +: 4]};
  assign f1_byte  = CH_ZERO + {4'd0, cur_r.digits[7:4]};
  assign f0_byte  = CH_ZERO + {4'd0, cur_r.digits[3:0]};

  always_comb begin
    case (hdr_cnt_r)
      3'd0:    hdr_byte = CH_LBRACK;
      3'd1:    hdr_byte = CH_S;
      3'd2:    hdr_byte = CH_COMMA;
      3'd3:    hdr_byte = cur_r.target;
      default: hdr_byte = CH_COMMA;
    endcase
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.frame_byte  = byte_r;
  assign out_if.last_byte   = last_r;
  assign out_if.frame_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_if.ready && !emit) out_vld_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            cur_r     <= q_entry;
            hdr_cnt_r <= '0;
            state_r   <= q_entry.err ? B_ERR : B_HDR;
          end
        end
        B_HDR: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= hdr_byte;
            last_r    <= 1'b0;
            err_r     <= 1'b0;
            hdr_cnt_r <= hdr_cnt_r + 3'd1;
            if (hdr_cnt_r == 3'd4) begin
              dig_ptr_r <= cur_r.nint + DIG_PTR_W'(1);
              state_r   <= cur_r.neg ? B_SIGN : B_INT;
            end
          end
        end
        B_SIGN: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= CH_MINUS;
            last_r    <= 1'b0;
            err_r     <= 1'b0;
            state_r   <= B_INT;
          end
        end
        B_INT: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= int_byte;
            last_r    <= 1'b0;
            err_r     <= 1'b0;
            dig_ptr_r <= dig_ptr_r - DIG_PTR_W'(1);
            if (dig_ptr_r == DIG_PTR_W'(2)) state_r <= B_DOT;
          end
        end
        B_DOT: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= CH_DOT;
            last_r    <= 1'b0;
            err_r     <= 1'b0;
            state_r   <= B_F1;
          end
        end
        B_F1: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= f1_byte;
            last_r    <= 1'b0;
            err_r     <= 1'b0;
            state_r   <= B_F0;
          end
        end
        B_F0: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= f0_byte;
            last_r    <= 1'b0;
            err_r     <= 1'b0;
            state_r   <= B_END;
          end
        end
        B_END: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= CH_RBRACK;
            last_r    <= 1'b1;
            err_r     <= 1'b0;
            state_r   <= B_IDLE;
          end
        end
        B_ERR: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            byte_r    <= CH_NULL;
            last_r    <= 1'b1;
            err_r     <= 1'b1;
            state_r   <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
